// File: hdl/dual_bitmap_first_free_finder_assert.svh
// ----------------------------------------------------------------------------
// Dual bitmap first-free finder: assertion macros
// Clocked on clk and disabled during rst in the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef DUAL_BITMAP_FIRST_FREE_FINDER_ASSERT_SVH
`define DUAL_BITMAP_FIRST_FREE_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBFF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dbff_pkg.sv
// ----------------------------------------------------------------------------
// dbff_pkg
// Shared types and constants of the dual bitmap first-free finder.
// ----------------------------------------------------------------------------
package dbff_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WORD_IDX_W = 6;
  localparam int BYTE_BITS  = 8;
  localparam int BYTE_IDX_W = 3;
  localparam int WORD_BYTES = WORD_BITS / BYTE_BITS;
  localparam int POS_W      = 12;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_TOGGLE,
    ST_DONE
  } state_t;

  // Result of the lowest-zero search over one word.
  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } zf_res_t;

endpackage

// File: hdl/dbff_chan_if.sv
// ----------------------------------------------------------------------------
// dbff channel interfaces
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbff_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        map_select;
  logic [11:0] bit_index;

  modport source (output valid, output opcode, output map_select, output bit_index,
                  input ready);
  modport sink   (input valid, input opcode, input map_select, input bit_index,
                  output ready);
endinterface

interface dbff_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] position;
  logic        none_free;
  logic        bit_now;

  modport source (output valid, output position, output none_free, output bit_now,
                  input ready);
  modport sink   (input valid, input position, input none_free, input bit_now,
                  output ready);
endinterface

// File: hdl/dbff_ram.sv
// ----------------------------------------------------------------------------
// dbff_ram
// Bitmap word store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module dbff_ram #(
  parameter int AW = 7,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dbff_zero_find.sv
// ----------------------------------------------------------------------------
// dbff_zero_find
// Finds the lowest zero bit of one bitmap word, byte by byte.
// ----------------------------------------------------------------------------
module dbff_zero_find (
  input  logic [dbff_pkg::WORD_BITS-1:0] word,
  output dbff_pkg::zf_res_t              res
);

  logic [dbff_pkg::WORD_BYTES-1:0] byte_free;
  logic [dbff_pkg::BYTE_IDX_W-1:0] byte_low [dbff_pkg::WORD_BYTES];
  logic [dbff_pkg::BYTE_IDX_W-1:0] byte_sel;

  // Lowest zero inside each byte; scanning downward leaves the lowest one.
  always_comb begin
    for (int b = 0; b < dbff_pkg::WORD_BYTES; b++) begin
      byte_free[b] = ~&word[b*dbff_pkg::BYTE_BITS +: dbff_pkg::BYTE_BITS];
      byte_low[b]  = '0;
      for (int k = dbff_pkg::BYTE_BITS - 1; k >= 0; k--) begin
        if (!word[b*dbff_pkg::BYTE_BITS + k]) begin
          byte_low[b] = dbff_pkg::BYTE_IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    byte_sel = '0;
    for (int b = dbff_pkg::WORD_BYTES - 1; b >= 0; b--) begin
      if (byte_free[b]) begin
        byte_sel = dbff_pkg::BYTE_IDX_W'(b);
      end
    end
    res.found = |byte_free;
    res.idx   = {byte_sel, byte_low[byte_sel]};
  end

endmodule

// File: hdl/dual_bitmap_first_free_finder.sv
// ----------------------------------------------------------------------------
// Find: one 64-bit word per cycle goes through a single search unit, until a
// word with a free bit or the last word ends the search. Toggle: one
// read-modify-write of the word. Either result is registered, then moved to
// the output register; a new request is taken only after that move. The
// result register lets the next request be taken while a result waits. After
// rst a clearing pass zeroes every word of both maps in the store.
// ----------------------------------------------------------------------------
// dual_bitmap_first_free_finder
// Two allocation bitmaps with find-first-free and toggle-bit requests.
// ----------------------------------------------------------------------------
module dual_bitmap_first_free_finder #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic      clk,
  input  logic      rst,
  dbff_in_if.sink   in_chan,
  dbff_out_if.source out_chan
);

  localparam int WORD_W    = dbff_pkg::WORD_BITS;
  localparam int MAP_BITS  = 8 * BLOCK_BYTES;
  localparam int WPM       = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WW        = (WPM > 1) ? $clog2(WPM) : 1;
  localparam int AW        = WW + 1;
  localparam int LAST_BITS = MAP_BITS - (WPM - 1) * WORD_W;
  localparam logic [WORD_W-1:0] PAD_MASK = ~({WORD_W{1'b1}} >> (WORD_W - LAST_BITS));
  localparam logic [WW-1:0]     LAST_WORD = WW'(WPM - 1);

  dbff_pkg::state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic [WW-1:0]     chk_w;
  logic              sel;
  logic [11:0]       idx;
  logic [11:0]       res_pos;
  logic              res_full;
  logic              res_now;
  logic              out_valid;
  logic [11:0]       out_pos;
  logic              out_full;
  logic              out_now;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [WW-1:0]     tgl_word;
  logic [WW-1:0]     in_word;
  logic              tgl_in_range;
  logic [dbff_pkg::WORD_IDX_W-1:0] tgl_bit;
  logic [WORD_W-1:0] tgl_mask;
  logic [WORD_W-1:0] scan_word;
  logic              out_free;
  dbff_pkg::zf_res_t zf;

  dbff_ram #(
    .AW (AW),
    .DW (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dbff_zero_find u_zero_find (
    .word (scan_word),
    .res  (zf)
  );

  assign tgl_word     = WW'(idx >> dbff_pkg::WORD_IDX_W);
  assign in_word      = WW'(in_chan.bit_index >> dbff_pkg::WORD_IDX_W);
  assign tgl_in_range = (32'(idx) < 32'(MAP_BITS));
  assign tgl_bit      = idx[dbff_pkg::WORD_IDX_W-1:0];
  assign tgl_mask     = {{(WORD_W-1){1'b0}}, 1'b1} << tgl_bit;
  // Bits past the end of a short map read as used.
  assign scan_word    = mem_rdata | ((chk_w == LAST_WORD) ? PAD_MASK : '0);
  assign out_free     = !out_valid || out_chan.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      dbff_pkg::ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) begin
          state_next = dbff_pkg::ST_IDLE;
        end
      end
      dbff_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_next = (in_chan.opcode == dbff_pkg::OP_FIND) ? dbff_pkg::ST_FIND
                                                              : dbff_pkg::ST_TOGGLE;
        end
      end
      dbff_pkg::ST_FIND: begin
        if (zf.found || chk_w == LAST_WORD) begin
          state_next = dbff_pkg::ST_DONE;
        end
      end
      dbff_pkg::ST_TOGGLE: begin
        state_next = dbff_pkg::ST_DONE;
      end
      dbff_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = dbff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dbff_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr;
    mem_wdata     = '0;
    mem_raddr     = {sel, chk_w};
    unique case (state)
      dbff_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      dbff_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        mem_raddr     = {in_chan.map_select,
                         (in_chan.opcode == dbff_pkg::OP_FIND) ? WW'(0) : in_word};
      end
      dbff_pkg::ST_FIND: begin
        // Fetch the next word while the current one is searched.
        mem_raddr = {sel, WW'(chk_w + WW'(1))};
      end
      dbff_pkg::ST_TOGGLE: begin
        mem_we    = tgl_in_range;
        mem_waddr = {sel, tgl_word};
        mem_wdata = mem_rdata ^ tgl_mask;
      end
      dbff_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dbff_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dbff_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      out_valid <= (out_valid && !out_chan.ready) ||
                   (state == dbff_pkg::ST_DONE && out_free);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dbff_pkg::ST_IDLE: begin
        sel   <= in_chan.map_select;
        idx   <= in_chan.bit_index;
        chk_w <= '0;
      end
      dbff_pkg::ST_FIND: begin
        chk_w    <= chk_w + WW'(1);
        res_pos  <= zf.found ? 12'({chk_w, zf.idx}) : '0;
        res_full <= !zf.found;
        res_now  <= 1'b0;
      end
      dbff_pkg::ST_TOGGLE: begin
        res_pos  <= idx;
        res_full <= 1'b0;
        res_now  <= tgl_in_range & ~mem_rdata[tgl_bit];
      end
      dbff_pkg::ST_DONE: begin
        if (out_free) begin
          out_pos  <= res_pos;
          out_full <= res_full;
          out_now  <= res_now;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid     = out_valid;
  assign out_chan.position  = out_pos;
  assign out_chan.none_free = out_full;
  assign out_chan.bit_now   = out_now;

endmodule

// File: hdl/dbff_checker.sv
// ----------------------------------------------------------------------------
// dbff_checker
// Port-level checks of the dual bitmap first-free finder, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_bitmap_first_free_finder_assert.svh"

module dbff_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] position,
  input logic        none_free,
  input logic        bit_now
);

  logic        stalled;
  logic        in_take;
  logic        full_clean;
  logic [13:0] result_bits;

  assign stalled     = out_valid && !out_ready;
  assign in_take     = in_valid && in_ready;
  assign full_clean  = (position == 12'd0) && !bit_now;
  assign result_bits = {position, none_free, bit_now};

  `DBFF_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(result_bits), "result not held")
  `DBFF_ASSERT_NEXT(a_busy_after_take, in_take, !in_ready, "request taken while busy")
  `DBFF_ASSERT_SAME(a_full_pos_zero, out_valid && none_free, full_clean, "full result not clean")
  `DBFF_ASSERT_SAME(a_bit_not_full, out_valid && bit_now, !none_free, "toggle result marked full")

endmodule

bind dual_bitmap_first_free_finder dbff_checker u_dbff_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .position  (out_chan.position),
  .none_free (out_chan.none_free),
  .bit_now   (out_chan.bit_now)
);

// File: test/dual_bitmap_first_free_finder_tb.sv
// ----------------------------------------------------------------------------
// dual_bitmap_first_free_finder_tb
// Drives find and toggle requests into both allocation maps and checks every
// result against a bit-level copy of the two maps kept in the testbench.
// The tests cover directed edge cases, filling the low end of both maps,
// output backpressure, and a random mix of finds, toggles and allocations.
// ----------------------------------------------------------------------------
module dual_bitmap_first_free_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES   = 512;
  localparam int MAP_BITS      = 8 * BLOCK_BYTES;
  localparam int MAX_IDLE      = 11;
  localparam int DRAIN_CYCLES  = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int FILL_BITS     = 72;
  localparam int RANDOM_ITEMS  = 340;

  typedef struct packed {
    logic [dbff_pkg::POS_W-1:0] position;
    logic                       none_free;
    logic                       bit_now;
  } bitmap_result_t;

  logic clk;
  logic rst;

  dbff_in_if  in_ch ();
  dbff_out_if out_ch ();

  dual_bitmap_first_free_finder #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  // Testbench copy of the two allocation maps, bit p of map m at alloc_map[m][p].
  logic [MAP_BITS-1:0] alloc_map [2];
  bitmap_result_t      pending_results [$];

  int          fail_count = 0;
  int          find_count;
  int          toggle_count;
  int          full_seen_count;
  bit          request_idle_on;
  bit          result_idle_on;
  bit          hold_req;
  bit          hold_seen;
  int unsigned result_wait;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bitmap_result_t model_bitmap_request(input logic op, input logic sel,
                                                           input logic [11:0] idx);
    bitmap_result_t res;
    res = '0;
    if (op == dbff_pkg::OP_FIND) begin
      res.none_free = 1'b1;
      for (int p = 0; p < MAP_BITS; p++) begin
        if (!alloc_map[sel][p]) begin
          res.position  = p[11:0];
          res.none_free = 1'b0;
          break;
        end
      end
    end else begin
      res.position = idx;
      if (int'(idx) < MAP_BITS) begin
        alloc_map[sel][idx] = ~alloc_map[sel][idx];
        res.bit_now = alloc_map[sel][idx];
      end
    end
    return res;
  endfunction

  function automatic void check_result(input bitmap_result_t got);
    bitmap_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: position %0d none_free %0b bit_now %0b",
             got.position, got.none_free, got.bit_now);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      fail_count++;
    end
    if (got.none_free !== want.none_free) begin
      $error("none_free: expected %0b, got %0b", want.none_free, got.none_free);
      fail_count++;
    end
    if (got.bit_now !== want.bit_now) begin
      $error("bit_now: expected %0b, got %0b", want.bit_now, got.bit_now);
      fail_count++;
    end
  endfunction

  // Result side: random stall after each transfer while enabled, plus a long hold when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      result_wait = 0;
      hold_seen   = hold_req;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result('{out_ch.position, out_ch.none_free, out_ch.bit_now});
        result_wait = result_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (result_wait != 0) begin
        result_wait--;
      end
      if (hold_seen != hold_req) begin
        result_wait = HOLD_CYCLES;
        hold_seen   = hold_req;
      end
      out_ch.ready <= (result_wait == 0);
    end
  end

  // Valid stays high after a transfer; it only drops when a gap is drawn or the
  // stimulus pauses, so it never gets two assignments in one step.
  task automatic send_request(input logic op, input logic sel, input logic [11:0] idx,
                              output bitmap_result_t predicted);
    int unsigned gap;
    gap = request_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.map_select <= sel;
    in_ch.bit_index  <= idx;
    do @(posedge clk); while (!in_ch.ready);
    predicted = model_bitmap_request(op, sel, idx);
    pending_results.push_back(predicted);
    if (op == dbff_pkg::OP_FIND) begin
      find_count++;
      if (predicted.none_free) full_seen_count++;
    end else begin
      toggle_count++;
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_edges();
    bitmap_result_t r;
    send_request(dbff_pkg::OP_FIND,   1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_FIND,   1'b1, 12'hFFF, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_FIND,   1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'h001, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b1, 12'hFFF, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'hFFF, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'hAAA, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b1, 12'h555, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'h03F, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'h040, r);
    send_request(dbff_pkg::OP_FIND,   1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_FIND,   1'b1, 12'h000, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_FIND,   1'b0, 12'h000, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b1, 12'hFFF, r);
    send_request(dbff_pkg::OP_TOGGLE, 1'b1, 12'h000, r);
    send_request(dbff_pkg::OP_FIND,   1'b1, 12'h000, r);
    wait_for_drain();
  endtask

  // Sets every free bit at the low end of both maps back to back, so a find has
  // to pass a fully used word, then frees a hole and finds it again.
  task automatic test_fill_maps();
    bitmap_result_t r;
    logic [11:0] hole;
    request_idle_on = 1'b0;
    result_idle_on  = 1'b0;
    for (int m = 0; m < 2; m++) begin
      for (int p = 0; p < FILL_BITS; p++) begin
        if (!alloc_map[m][p]) send_request(dbff_pkg::OP_TOGGLE, m[0], p[11:0], r);
      end
      send_request(dbff_pkg::OP_FIND, m[0], 12'($urandom_range(0, MAP_BITS - 1)), r);
    end
    request_idle_on = 1'b1;
    result_idle_on  = 1'b1;
    for (int m = 0; m < 2; m++) begin
      hole = 12'($urandom_range(0, FILL_BITS - 1));
      send_request(dbff_pkg::OP_TOGGLE, m[0], 12'hFFF, r);
      send_request(dbff_pkg::OP_FIND,   m[0], 12'h000, r);
      send_request(dbff_pkg::OP_TOGGLE, m[0], hole, r);
      send_request(dbff_pkg::OP_FIND,   m[0], 12'h000, r);
      send_request(dbff_pkg::OP_TOGGLE, m[0], 12'hFFF, r);
      send_request(dbff_pkg::OP_FIND,   m[0], 12'h000, r);
    end
    wait_for_drain();
  endtask

  // The result side stalls while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    bitmap_result_t r;
    request_idle_on = 1'b0;
    hold_req        = ~hold_req;
    for (int i = 0; i < 24; i++) begin
      send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   12'($urandom_range(0, MAP_BITS - 1)), r);
    end
    request_idle_on = 1'b1;
    wait_for_drain();
  endtask

  // Allocations (a find followed by setting the bit it returned), toggles of
  // random bits and lone finds, mixed at random.
  task automatic test_random_traffic();
    bitmap_result_t r;
    int unsigned pick;
    logic sel;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      sel  = 1'($urandom_range(0, 1));
      if (i % 200 == 199) begin
        request_idle_on = ~request_idle_on;
        result_idle_on  = ~result_idle_on;
      end
      if (pick < 25) begin
        send_request(dbff_pkg::OP_FIND, sel, 12'($urandom_range(0, MAP_BITS - 1)), r);
      end else if (pick < 60) begin
        send_request(dbff_pkg::OP_FIND, sel, 12'($urandom_range(0, MAP_BITS - 1)), r);
        if (!r.none_free) send_request(dbff_pkg::OP_TOGGLE, sel, r.position, r);
      end else begin
        send_request(dbff_pkg::OP_TOGGLE, sel, 12'($urandom_range(0, MAP_BITS - 1)), r);
      end
    end
    request_idle_on = 1'b1;
    result_idle_on  = 1'b1;
    wait_for_drain();
  endtask

  initial begin
    alloc_map[0]     = '0;
    alloc_map[1]     = '0;
    find_count       = 0;
    toggle_count     = 0;
    full_seen_count  = 0;
    request_idle_on  = 1'b1;
    result_idle_on   = 1'b1;
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= dbff_pkg::OP_FIND;
    in_ch.map_select <= 1'b0;
    in_ch.bit_index  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_maps();
    test_output_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d finds and %0d toggles over both maps, %0d finds on a full map.",
             find_count, toggle_count, full_seen_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dbff_pkg.sv
hdl/dbff_chan_if.sv
hdl/dbff_ram.sv
hdl/dbff_zero_find.sv
hdl/dual_bitmap_first_free_finder.sv
hdl/dbff_checker.sv
test/dual_bitmap_first_free_finder_tb.sv
